// File: src/ghpdf_pkg.sv
package ghpdf_pkg;

    // Histogram geometry and counter width
    localparam int BIN_COUNT  = 256;
    localparam int COUNT_BITS = 24;
    localparam int IDX_BITS   = $clog2(BIN_COUNT);

    // Port field widths
    localparam int OP_W  = 2;
    localparam int PIX_W = 8;
    localparam int OUT_W = 24;

    // Q1.16 probability: 16 fraction bits, 17 bits to hold exactly one
    localparam int FRAC_BITS = 16;
    localparam int PROB_BITS = FRAC_BITS + 1;
    localparam logic [PROB_BITS-1:0] PROB_ONE = PROB_BITS'(1) << FRAC_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_RDWAIT,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic accept;     // latch the item, issue the bin read
        logic clear;      // zero all bins and the total
        logic wr_add;     // write back the incremented bin
        logic div_start;  // start the probability divide
        logic load_out;   // fill the output register
    } t_dp_cmd;

    typedef struct packed {
        logic add_ok;     // presented item is an add to a bin that exists
        logic op_read;    // presented item is a read
        logic op_clear;   // presented item is a clear
        logic total_zero; // running total is zero
        logic div_done;   // divide finished this cycle
    } t_dp_status;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : COUNT_BITS'(v + 1'b1);
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_W-1:0];
    endfunction

endpackage

// File: src/ghpdf_ram.sv
module ghpdf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/ghpdf_div.sv
module ghpdf_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [ghpdf_pkg::COUNT_BITS-1:0]    i_num,
    input  logic [ghpdf_pkg::COUNT_BITS-1:0]    i_den,
    output logic                                o_done,
    output logic [ghpdf_pkg::PROB_BITS-1:0]     o_quot
);

    import ghpdf_pkg::*;

    localparam int DW         = COUNT_BITS + PROB_BITS;
    localparam int STEP_BITS  = $clog2(PROB_BITS + 1);

    logic [DW-1:0]           w_dividend;
    logic [COUNT_BITS:0]     w_trial;
    logic                    w_ge;

    logic [COUNT_BITS:0]     r_rem,  n_rem;
    logic [PROB_BITS-1:0]    r_low,  n_low;
    logic [PROB_BITS-1:0]    r_quot, n_quot;
    logic [COUNT_BITS-1:0]   r_den,  n_den;
    logic [STEP_BITS-1:0]    r_step, n_step;
    logic                    r_busy, n_busy;
    logic                    r_done, n_done;

    // Rounded dividend: num * 2^16 + den / 2. With num <= den the top
    // COUNT_BITS bits start below den, so 17 quotient bits suffice.
    assign w_dividend = {1'b0, i_num, {FRAC_BITS{1'b0}}} + DW'(i_den >> 1);
    assign w_trial    = {r_rem[COUNT_BITS-1:0], r_low[PROB_BITS-1]};
    assign w_ge       = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_rem  = r_rem;
        n_low  = r_low;
        n_quot = r_quot;
        n_den  = r_den;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = {1'b0, w_dividend[DW-1:PROB_BITS]};
            n_low  = w_dividend[PROB_BITS-1:0];
            n_quot = '0;
            n_den  = i_den;
            n_step = STEP_BITS'(PROB_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
            n_low  = {r_low[PROB_BITS-2:0], 1'b0};
            n_quot = {r_quot[PROB_BITS-2:0], w_ge};
            n_step = r_step - 1'b1;
            if (r_step == STEP_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem  <= n_rem;
        r_low  <= n_low;
        r_quot <= n_quot;
        r_den  <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: src/ghpdf_dp.sv
module ghpdf_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ghpdf_pkg::t_dp_cmd              i_cmd,
    output ghpdf_pkg::t_dp_status           o_st,
    input  logic [ghpdf_pkg::OP_W-1:0]      i_operation,
    input  logic [ghpdf_pkg::PIX_W-1:0]     i_pixel_value,
    input  logic [ghpdf_pkg::PIX_W-1:0]     i_bin_index,
    output logic [ghpdf_pkg::OUT_W-1:0]     o_bin_count,
    output logic [ghpdf_pkg::PROB_BITS-1:0] o_bin_probability,
    output logic [ghpdf_pkg::OUT_W-1:0]     o_pixel_total
);

    import ghpdf_pkg::*;

    logic                   w_pix_ok;
    logic                   w_idx_ok;
    logic                   w_is_add;
    logic [IDX_BITS-1:0]    w_addr;
    logic [COUNT_BITS-1:0]  w_ram_q;
    logic [COUNT_BITS-1:0]  w_cur;
    logic [COUNT_BITS-1:0]  w_cnt;
    logic                   w_div_done;
    logic [PROB_BITS-1:0]   w_quot;
    logic [PROB_BITS-1:0]   w_prob;

    logic [BIN_COUNT-1:0]   r_valid;
    logic                   r_rd_valid;
    logic [IDX_BITS-1:0]    r_addr;
    logic                   r_in_range;
    logic [COUNT_BITS-1:0]  r_total;
    logic [OUT_W-1:0]       r_out_count;
    logic [PROB_BITS-1:0]   r_out_prob;
    logic [OUT_W-1:0]       r_out_total;

    assign w_pix_ok = ({1'b0, i_pixel_value} < (PIX_W + 1)'(BIN_COUNT));
    assign w_idx_ok = ({1'b0, i_bin_index}   < (PIX_W + 1)'(BIN_COUNT));
    assign w_is_add = (i_operation == OP_ADD);
    assign w_addr   = w_is_add ? i_pixel_value[IDX_BITS-1:0] : i_bin_index[IDX_BITS-1:0];

    assign o_st.add_ok     = w_is_add && w_pix_ok;
    assign o_st.op_read    = (i_operation == OP_READ);
    assign o_st.op_clear   = (i_operation == OP_CLEAR);
    assign o_st.total_zero = (r_total == '0);
    assign o_st.div_done   = w_div_done;

    ghpdf_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BIN_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_add),
        .i_wr_addr (r_addr),
        .i_wr_data (sat_inc(w_cur)),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (w_addr),
        .o_rd_data (w_ram_q)
    );

    // A bin not written since the last clear reads as zero
    assign w_cur = r_rd_valid ? w_ram_q : '0;
    assign w_cnt = r_in_range ? w_cur : '0;

    ghpdf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_cnt),
        .i_den   (r_total),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_prob = (r_total == '0) ? '0 :
                    (w_quot > PROB_ONE) ? PROB_ONE : w_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_valid <= '0;
            r_total <= '0;
        end else if (i_cmd.wr_add) begin
            r_valid[r_addr] <= 1'b1;
            r_total         <= sat_inc(r_total);
        end
    end

    // The bin read stays on the RAM output until the next item is taken
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr     <= w_addr;
            r_in_range <= w_is_add ? w_pix_ok : w_idx_ok;
            r_rd_valid <= r_valid[w_addr];
        end
        if (i_cmd.load_out) begin
            r_out_count <= to_out(w_cnt);
            r_out_prob  <= w_prob;
            r_out_total <= to_out(r_total);
        end
    end

    assign o_bin_count       = r_out_count;
    assign o_bin_probability = r_out_prob;
    assign o_pixel_total     = r_out_total;

endmodule

// File: src/ghpdf_ctrl.sv
module ghpdf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output ghpdf_pkg::t_dp_cmd    o_cmd,
    input  ghpdf_pkg::t_dp_status i_st
);

    import ghpdf_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.clear  = i_st.op_clear;
                    if (i_st.add_ok) begin
                        n_state = S_ADD;
                    end else if (i_st.op_read) begin
                        n_state = S_RDWAIT;
                    end
                end
            end
            S_ADD: begin
                o_cmd.wr_add = 1'b1;
                n_state      = S_IDLE;
            end
            S_RDWAIT: begin
                if (i_st.total_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_st.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: src/gray_histogram_pdf_core.sv
// Add item: bin read, then write back; clear item: done when accepted.
// Read item: bin read, then the 17-step restoring divider for the
// probability, then the output load; the next item is taken after that.
// A read with a zero total skips the divide.
// Reset (synchronous, active low) clears the bin valid flags and the total at
// once, so every bin reads as zero straight after reset; no clearing pass.
module gray_histogram_pdf_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ghpdf_pkg::OP_W-1:0]      i_operation,
    input  logic [ghpdf_pkg::PIX_W-1:0]     i_pixel_value,
    input  logic [ghpdf_pkg::PIX_W-1:0]     i_bin_index,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ghpdf_pkg::OUT_W-1:0]     o_bin_count,
    output logic [ghpdf_pkg::PROB_BITS-1:0] o_bin_probability,
    output logic [ghpdf_pkg::OUT_W-1:0]     o_pixel_total
);

    import ghpdf_pkg::*;

    // Command and status between the sequencer and the datapath.
    t_dp_cmd    w_cmd;
    t_dp_status w_st;

    // Sequencer: take one item at a time, walk it through read, write-back
    // or divide, and hold the result in the output register until taken.
    // The next item is accepted while a finished result still waits; only a
    // read that reaches its output step waits for the register to free up.
    ghpdf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .i_st        (w_st)
    );

    // Datapath: bin store (RAM plus per-bin valid flags so a clear needs no
    // pass over the RAM), saturating counters, the probability divider with
    // round-to-nearest, and the output register.
    // Drop pixels beyond the bins; a read beyond the bins returns zero count.
    ghpdf_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_st              (w_st),
        .i_operation       (i_operation),
        .i_pixel_value     (i_pixel_value),
        .i_bin_index       (i_bin_index),
        .o_bin_count       (o_bin_count),
        .o_bin_probability (o_bin_probability),
        .o_pixel_total     (o_pixel_total)
    );

endmodule
